/* sv/cpc_pkg.sv */
// ----------------------------------------------------------------------------
// cpc_pkg: shared constants and a helper function of the contrast pixel counter
// Register indexes, field widths, reset values and the contrast compare.
// ----------------------------------------------------------------------------
package cpc_pkg;

	// default line store and frame limits
	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 256;

	// field widths
	localparam int PIX_W      = 8;
	localparam int FWIDTH_W   = 10;
	localparam int FHEIGHT_W  = 9;
	localparam int THRESH_W   = 8;
	localparam int COUNT_W    = 18;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

	// register reset values
	localparam logic [FWIDTH_W-1:0]  RST_FRAME_WIDTH  = 10'd320;
	localparam logic [FHEIGHT_W-1:0] RST_FRAME_HEIGHT = 9'd200;
	localparam logic [THRESH_W-1:0]  RST_THRESHOLD    = 8'd128;

	// saturation limit of the running count
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// absolute difference of two grey levels above the threshold
	function automatic logic cpc_differs(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [THRESH_W-1:0] thr);
		logic [PIX_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d > thr;
	endfunction

endpackage

/* sv/cpc_pixel_if.sv */
// ----------------------------------------------------------------------------
// cpc_pixel_if: pixel input channel
// Valid/ready channel carrying one grey pixel per word.
// ----------------------------------------------------------------------------
interface cpc_pixel_if;
	import cpc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source(output valid, output pixel_value, input ready);
	modport sink(input valid, input pixel_value, output ready);

endinterface

/* sv/cpc_count_if.sv */
// ----------------------------------------------------------------------------
// cpc_count_if: frame count output channel
// Valid/ready channel carrying one contrast count word per frame.
// ----------------------------------------------------------------------------
interface cpc_count_if;
	import cpc_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] contrast_count;

	modport source(output valid, output contrast_count, input ready);
	modport sink(input valid, input contrast_count, output ready);

endinterface

/* sv/cpc_line_store.sv */
// ----------------------------------------------------------------------------
// cpc_line_store: one-row line store with write-to-read forwarding
// Synchronous memory, one write and one read port, registered read data.
// A write in the same cycle as a read of the same entry is forwarded.
// ----------------------------------------------------------------------------
module cpc_line_store #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] byp_data_q;
	logic              byp_valid_q;

	// memory array write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// capture a colliding write for the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (rd_en) begin
			byp_valid_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_data_q <= wr_data;
		end
	end

	assign rd_data = byp_valid_q ? byp_data_q : rd_q;

endmodule

/* sv/contrast_pixel_counter_top.sv */
// ----------------------------------------------------------------------------
// contrast_pixel_counter_top: four-neighbour contrast pixel counter
//
// Pixels of a frame enter in raster order on the pixels channel, one word
// per accepted handshake. A pixel counts when it differs from its up, down,
// left or right neighbour by more than the threshold register; neighbours
// outside the frame are ignored. On the frame's last pixel one word with
// the frame's count leaves on the counts channel, and a new frame starts.
// Throughput: one pixel per cycle unless the pixels channel stalls. Each
// pixel does one read of the line store at accept and one write-back when
// it leaves stage 1; a write that hits the entry being read is forwarded.
// The count word is registered in the output register when the frame's
// last pixel leaves stage 1. The output register lets pixels keep flowing
// while a count waits; the pixels channel stalls only when the next frame's
// count is due and the previous one has not been taken.
// Reset: registers take their reset values and the frame position goes to
// the first pixel. The line store is not cleared; the first row ignores
// what it reads. Configuration writes take effect at once and are meant to be
// done while no pixel is in flight.
// ----------------------------------------------------------------------------
module contrast_pixel_counter_top #(
	parameter int MAX_WIDTH  = cpc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cpc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_data,
	cpc_pixel_if.sink                      pixels,
	cpc_count_if.source                    counts
);
	import cpc_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int XW0 = (CW > RW) ? CW + 2 : RW + 2;
	localparam int XW  = (XW0 > FWIDTH_W + 1) ? XW0 : FWIDTH_W + 1;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [CW-1:0]    col;
		logic             has_up;
		logic             has_left;
		logic             row_end;
		logic             last_row;
	} stage_t;

	// configuration registers
	logic [FWIDTH_W-1:0]  frame_width_q;
	logic [FHEIGHT_W-1:0] frame_height_q;
	logic [THRESH_W-1:0]  threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			threshold_q    <= RST_THRESHOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FWIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FHEIGHT_W-1:0];
				REG_THRESHOLD:    threshold_q    <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// frame position and stage 1 control
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [XW-1:0] col_next;
	logic [XW-1:0] row_next;
	logic          row_end;
	logic          last_row;
	logic          accept;
	logic          s1_valid_q;
	stage_t        s1_q;
	logic          s1_stall;
	logic          s1_fire;
	logic          frame_end;
	logic          out_valid_q;
	logic [COUNT_W-1:0] out_count_q;

	assign col_next = XW'(col_q) + XW'(1);
	assign row_next = XW'(row_q) + XW'(1);
	// a zero width or height register reads as one, large values as the maximum
	assign row_end  = (col_next >= XW'(frame_width_q)) || (col_next >= XW'(MAX_WIDTH));
	assign last_row = (row_next >= XW'(frame_height_q)) || (row_next >= XW'(MAX_HEIGHT));

	assign frame_end    = s1_q.row_end && s1_q.last_row;
	assign s1_stall     = s1_valid_q && frame_end && out_valid_q && !counts.ready;
	assign s1_fire      = s1_valid_q && !s1_stall;
	assign pixels.ready = !s1_stall;
	assign accept       = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_next[RW-1:0];
				end else begin
					col_q <= col_next[CW-1:0];
				end
			end
			if (!s1_stall) begin
				s1_valid_q <= accept;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.pix      <= pixels.pixel_value;
			s1_q.col      <= col_q;
			s1_q.has_up   <= (row_q != '0);
			s1_q.has_left <= (col_q != '0);
			s1_q.row_end  <= row_end;
			s1_q.last_row <= last_row;
		end
	end

	// line stores: pixels and pending flags of the row above
	logic [PIX_W-1:0] above_pix;
	logic             above_flag_mem;
	logic             flag_we;
	logic [CW-1:0]    flag_waddr;
	logic             flag_wdata;
	logic             left_flag_new;

	cpc_line_store #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_pix_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (above_pix),
		.wr_en   (s1_fire),
		.wr_addr (s1_q.col),
		.wr_data (s1_q.pix)
	);

	cpc_line_store #(.DATA_W(1), .DEPTH(MAX_WIDTH)) u_flag_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (above_flag_mem),
		.wr_en   (flag_we),
		.wr_addr (flag_waddr),
		.wr_data (flag_wdata)
	);

	// flag of the row's last column, held aside until the next row's
	// first pixel, which has no left write, stores it
	logic          lastf_valid_q;
	logic          lastf_q;
	logic [CW-1:0] lastf_col_q;

	// contrast evaluation of the pixel in stage 1
	logic             left_flag_q;
	logic [PIX_W-1:0] left_pix_q;
	logic             above_flag;
	logic             diff_up;
	logic             diff_left;
	logic             cur_flag;
	logic             up_final;
	logic [1:0]       add_n;
	logic [COUNT_W:0] count_sum;
	logic [COUNT_W-1:0] count_sat;
	logic [COUNT_W-1:0] count_q;

	assign above_flag = (lastf_valid_q && (lastf_col_q == s1_q.col)) ? lastf_q
			: above_flag_mem;
	assign diff_up    = s1_q.has_up && cpc_differs(s1_q.pix, above_pix, threshold_q);
	assign diff_left  = s1_q.has_left && cpc_differs(s1_q.pix, left_pix_q, threshold_q);
	assign cur_flag   = diff_up || diff_left;
	assign up_final   = s1_q.has_up && (above_flag || diff_up);
	assign left_flag_new = left_flag_q || diff_left;

	// left pixel's flag, or the held last-column flag on a row's first pixel
	assign flag_we    = s1_fire && (s1_q.has_left || lastf_valid_q);
	assign flag_waddr = s1_q.has_left ? (s1_q.col - CW'(1)) : lastf_col_q;
	assign flag_wdata = s1_q.has_left ? left_flag_new : lastf_q;

	assign add_n = 2'(up_final)
			+ 2'(s1_q.has_left && s1_q.last_row && left_flag_new)
			+ 2'(frame_end && cur_flag);
	assign count_sum = {1'b0, count_q} + (COUNT_W + 1)'(add_n);
	assign count_sat = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

	// left neighbour, last-column flag and running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_pix_q    <= '0;
			left_flag_q   <= 1'b0;
			lastf_valid_q <= 1'b0;
			lastf_q       <= 1'b0;
			lastf_col_q   <= '0;
			count_q       <= '0;
		end else if (s1_fire) begin
			if (s1_q.row_end) begin
				left_pix_q    <= '0;
				left_flag_q   <= 1'b0;
				lastf_valid_q <= 1'b1;
				lastf_q       <= cur_flag;
				lastf_col_q   <= s1_q.col;
			end else begin
				left_pix_q  <= s1_q.pix;
				left_flag_q <= cur_flag;
				if (flag_we && (flag_waddr == lastf_col_q)) begin
					lastf_valid_q <= 1'b0;
				end
			end
			count_q <= frame_end ? '0 : count_sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (counts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && frame_end) begin
			out_count_q <= count_sat;
		end
	end

	assign counts.valid          = out_valid_q;
	assign counts.contrast_count = out_count_q;

	// the input stalls only for a finished frame facing a full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> (s1_valid_q && frame_end && out_valid_q))
		else $error("pixel input stalled without a blocked frame count");

	// a waiting count is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && frame_end) |-> (!out_valid_q || counts.ready))
		else $error("frame count overwritten before being taken");

	// the running count restarts after each frame
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && frame_end) |=> (count_q == '0))
		else $error("running count not cleared at frame end");

	// the frame position wraps after the frame's last pixel
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row_end && last_row) |=> ((col_q == '0) && (row_q == '0)))
		else $error("frame position not reset after last pixel");

endmodule

/* tb/sv/tb_contrast_pixel_counter_top.sv */
// ----------------------------------------------------------------------------
// tb_contrast_pixel_counter_top: testbench of the contrast pixel counter
// Streams grey frames into the block and checks every frame count word
// against a built-in line-store predictor. Covers threshold and size
// extremes, saturated sizes, mid-frame register changes, random idling on
// both channels and a long output stall that backs up the pixel input.
// ----------------------------------------------------------------------------
module tb_contrast_pixel_counter_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cpc_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_PIXELS = 400;
	localparam int RANDOM_FRAMES = 12;

	typedef enum int {PAT_UNIFORM, PAT_BINARY, PAT_NEAR, PAT_SPOTS} pixel_pattern_e;

	// predicts frame counts from accepted pixels and checks count words
	class frame_count_scoreboard;
		logic [FWIDTH_W-1:0]  width_reg;
		logic [FHEIGHT_W-1:0] height_reg;
		logic [THRESH_W-1:0]  thresh_reg;
		logic [PIX_W-1:0]     line_pixels [DEF_MAX_WIDTH];
		bit                   line_flags [DEF_MAX_WIDTH];
		logic [PIX_W-1:0]     left_px;
		bit                   left_fl;
		int unsigned          col;
		int unsigned          row;
		logic [COUNT_W-1:0]   tally;
		logic [COUNT_W-1:0]   due_counts [$];
		int unsigned          errors;
		int unsigned          pixels_in;
		int unsigned          frames_done;
		int unsigned          counts_out;

		function new();
			width_reg  = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			thresh_reg = RST_THRESHOLD;
			foreach (line_pixels[i]) begin
				line_pixels[i] = '0;
				line_flags[i]  = 1'b0;
			end
			left_px = '0;
			left_fl = 1'b0;
			col = 0;
			row = 0;
			tally = '0;
			errors = 0;
			pixels_in = 0;
			frames_done = 0;
			counts_out = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH: width_reg = data[FWIDTH_W-1:0];
				REG_FRAME_HEIGHT: height_reg = data[FHEIGHT_W-1:0];
				REG_THRESHOLD: thresh_reg = data[THRESH_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned width_in_use();
			if (width_reg == 0)
				return 1;
			if (width_reg > DEF_MAX_WIDTH)
				return DEF_MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned height_in_use();
			if (height_reg == 0)
				return 1;
			if (height_reg > DEF_MAX_HEIGHT)
				return DEF_MAX_HEIGHT;
			return height_reg;
		endfunction

		function bit contrasts(int a, int b);
			int d;
			d = (a > b) ? a - b : b - a;
			return d > int'(thresh_reg);
		endfunction

		// saturating add of one settled flag
		function void bump(bit flag);
			if (flag && tally != COUNT_MAX)
				tally++;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] p);
			int unsigned w, h, c;
			bit cur, above_fl, row_end, last_row;
			w = width_in_use();
			h = height_in_use();
			c = col;
			cur = 1'b0;
			pixels_in++;
			if (c >= DEF_MAX_WIDTH)
				c = DEF_MAX_WIDTH - 1;
			row_end  = (c + 1 >= w);
			last_row = (row + 1 >= h);
			// vertical pair settles the pixel above
			if (row > 0) begin
				above_fl = line_flags[c];
				if (contrasts(p, line_pixels[c])) begin
					cur = 1'b1;
					above_fl = 1'b1;
				end
				bump(above_fl);
			end
			line_pixels[c] = p;
			// horizontal pair updates the left pixel's pending flag
			if (c > 0) begin
				if (contrasts(p, left_px)) begin
					cur = 1'b1;
					left_fl = 1'b1;
				end
				line_flags[c-1] = left_fl;
				if (last_row)
					bump(left_fl);
			end
			left_px = p;
			left_fl = cur;
			// end of row, and of frame on the last row
			if (row_end) begin
				line_flags[c] = cur;
				if (last_row)
					bump(cur);
				col = 0;
				left_px = '0;
				left_fl = 1'b0;
				if (last_row) begin
					due_counts.push_back(tally);
					frames_done++;
					tally = '0;
					row = 0;
				end else begin
					row = row + 1;
				end
			end else begin
				col = c + 1;
			end
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_count(logic [COUNT_W-1:0] got);
			logic [COUNT_W-1:0] want;
			counts_out++;
			if (due_counts.size() == 0) begin
				report($sformatf("count word %0d arrived with no frame finished", got));
			end else begin
				want = due_counts.pop_front();
				if (got !== want)
					report($sformatf("frame %0d: contrast_count %0d, expected %0d",
						counts_out, got, want));
			end
		endtask

		task close();
			while (due_counts.size() != 0)
				report($sformatf("frame count %0d never arrived", due_counts.pop_front()));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cpc_pixel_if pix_ch ();
	cpc_count_if cnt_ch ();

	frame_count_scoreboard board = new();

	bit             idling = 1'b1;
	bit             hold_request = 1'b0;
	int unsigned    holds_done = 0;
	int unsigned    settings_used = 0;
	int unsigned    quiet_cycles = 0;
	pixel_pattern_e pix_pattern = PAT_UNIFORM;
	int             level_base = 128;

	contrast_pixel_counter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_ch),
		.counts    (cnt_ch)
	);

	// clock
	always #HALF_PERIOD clk = ~clk;

	// handshake monitor: feeds the predictor and checks count words
	always @(posedge clk) begin
		if (arst_n) begin
			if (cnt_ch.valid && cnt_ch.ready)
				board.check_count(cnt_ch.contrast_count);
			if (pix_ch.valid && pix_ch.ready)
				board.note_pixel(pix_ch.pixel_value);
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_ch.valid && pix_ch.ready) || (cnt_ch.valid && cnt_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	// count receiver: random gaps, plus one long hold on request
	initial begin
		int gap;
		cnt_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				holds_done++;
				cnt_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			gap = idling ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				cnt_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			cnt_ch.ready = 1'b1;
			do @(posedge clk); while (!cnt_ch.valid);
			@(negedge clk);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		board.write_register(idx, data);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
			logic [CFG_DATA_W-1:0] thr);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_THRESHOLD, thr);
		settings_used++;
	endtask

	task automatic send_pixel(logic [PIX_W-1:0] v);
		int gap;
		gap = idling ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			pix_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.pixel_value = v;
		do @(posedge clk); while (!pix_ch.ready);
		@(negedge clk);
	endtask

	// stop offering pixels until every count is back and the pipe is empty
	task automatic settle();
		pix_ch.valid = 1'b0;
		while (board.due_counts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] draw_threshold();
		logic [THRESH_W-1:0] t;
		case ($urandom_range(0, 7))
			0: t = '0;
			1: t = '1;
			default: t = THRESH_W'($urandom_range(0, 255));
		endcase
		return {2'($urandom_range(0, 3)), t};
	endfunction

	function automatic logic [PIX_W-1:0] next_pixel();
		int v;
		int t;
		t = int'(board.thresh_reg);
		case (pix_pattern)
			PAT_UNIFORM: v = $urandom_range(0, 255);
			PAT_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
			PAT_NEAR: v = level_base + int'($urandom_range(0, 2 * t + 6)) - t - 3;
			default: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : level_base;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return PIX_W'(v);
	endfunction

	// stimulus
	initial begin
		int unsigned goal, px0, fr0, phase, k, wnew;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_value = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// checkerboard at threshold zero: every pixel counts
		set_frame(10'd3, 10'd3, 10'd0);
		for (int i = 0; i < 9; i++)
			send_pixel((((i % 3) + (i / 3)) % 2) ? 8'd255 : 8'd0);
		// full swing at the top threshold counts nothing
		settle();
		set_frame(10'd2, 10'd2, 10'd255);
		send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
		// one below the full swing counts everything
		settle();
		write_reg(REG_THRESHOLD, 10'd254);
		send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
		// zero sizes saturate to single-pixel frames
		settle();
		set_frame(10'd0, 10'd0, 10'd10);
		send_pixel(8'd255); send_pixel(8'd0);
		// shrink width and height in the middle of a frame
		settle();
		set_frame(10'd4, 10'd3, 10'd100);
		send_pixel(8'd0); send_pixel(8'd200); send_pixel(8'd0); send_pixel(8'd200);
		send_pixel(8'd200); send_pixel(8'd0);
		settle();
		write_reg(REG_FRAME_WIDTH, 10'd2);
		write_reg(REG_FRAME_HEIGHT, 10'd2);
		write_reg(REG_THRESHOLD, 10'd50);
		send_pixel(8'd90);

		// width register above the line store: the row runs on until cut short
		settle();
		set_frame(10'd1023, 10'd1, draw_threshold());
		repeat (20) send_pixel(next_pixel());
		settle();
		write_reg(REG_FRAME_WIDTH, 10'd24);
		repeat (4) send_pixel(next_pixel());

		// tiny frames with the count side held off: input backs up
		settle();
		set_frame(10'd2, 10'd1, draw_threshold());
		idling = 1'b0;
		pix_pattern = PAT_UNIFORM;
		hold_request = 1'b1;
		repeat (40) send_pixel(next_pixel());
		settle();

		// random phases, with a saturated height mixed in
		px0 = board.pixels_in;
		fr0 = board.frames_done;
		phase = 0;
		while (board.pixels_in - px0 < RANDOM_PIXELS || board.frames_done - fr0 < RANDOM_FRAMES) begin
			settle();
			idling = ($urandom_range(0, 3) != 0);
			pix_pattern = pixel_pattern_e'($urandom_range(0, 3));
			level_base = $urandom_range(0, 255);
			case (phase % 12)
				1: set_frame(10'd1, {1'($urandom_range(0, 1)), 9'h1FF}, draw_threshold());
				default: set_frame(10'($urandom_range(1, 8)),
					{1'($urandom_range(0, 1)), 9'($urandom_range(1, 6))}, draw_threshold());
			endcase
			goal = board.frames_done + ((phase % 12 == 1) ? 1 : $urandom_range(1, 3));
			// occasionally change registers partway through a frame
			if (phase % 12 != 1 && $urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, board.width_in_use() * board.height_in_use());
				repeat (k)
					if (board.frames_done < goal)
						send_pixel(next_pixel());
				settle();
				// never widen mid-frame: the line store past the old width is unwritten
				wnew = $urandom_range(1, board.width_in_use());
				write_reg(REG_FRAME_WIDTH, 10'(wnew));
				write_reg(REG_FRAME_HEIGHT, 10'($urandom_range(1, 6)));
				write_reg(REG_THRESHOLD, draw_threshold());
				settings_used++;
			end
			while (board.frames_done < goal)
				send_pixel(next_pixel());
			phase++;
		end

		// drain and wrap up
		settle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		board.close();
		$display("summary: %0d pixels, %0d frames, %0d count words, %0d register settings",
			board.pixels_in, board.frames_done, board.counts_out, settings_used);
		$display("summary: size saturation, threshold ends, mid-frame changes, %0d long stall(s)",
			holds_done);
		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
